/* src/acs_pkg.sv */
`default_nettype none

package acs_pkg;

    // Store geometry; addresses fold into the store by modulo depth
    localparam int STORE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int BYTE_VALS   = 256;

    typedef logic [7:0]        t_byte;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef t_addr [BYTE_VALS-1:0] t_slot_tbl;

    localparam t_byte HALT_FILL = 8'h0F;
    localparam t_byte DIV_ZERO_Q = 8'hFF;

    // Shared add/subtract unit: 9-bit operands, 10-bit result (top bit is carry on add, borrow on subtract)
    localparam int ALU_W = 9;
    typedef logic [ALU_W-1:0] t_alu_in;
    typedef logic [ALU_W:0]   t_alu_out;

    // Shift-add multiply and restoring divide run one bit per cycle
    localparam int ITER_STEPS = 8;
    localparam int CNT_W      = $clog2(ITER_STEPS);

    typedef enum logic [1:0] {
        FUNC_STEP  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_RESET = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        OP_LDM  = 4'd0,
        OP_LDI  = 4'd1,
        OP_STM  = 4'd2,
        OP_ADD  = 4'd3,
        OP_SUB  = 4'd4,
        OP_MUL  = 4'd5,
        OP_DIV  = 4'd6,
        OP_INC  = 4'd7,
        OP_DEC  = 4'd8,
        OP_AND  = 4'd9,
        OP_OR   = 4'd10,
        OP_NOT  = 4'd11,
        OP_JMP  = 4'd12,
        OP_JZ   = 4'd13,
        OP_JNZ  = 4'd14,
        OP_HALT = 4'd15
    } t_opcode;

    // Request from the sequencer to one store
    typedef struct packed {
        logic  clear;
        logic  we;
        t_addr waddr;
        t_byte wdata;
        t_addr raddr;
    } t_ram_req;

    // Byte address to store slot, built at elaboration
    function automatic t_slot_tbl f_slot_tbl();
        t_slot_tbl tbl;
        for (int i = 0; i < BYTE_VALS; i++) begin
            tbl[i] = ADDR_W'(i % STORE_DEPTH);
        end
        return tbl;
    endfunction

    localparam t_slot_tbl SLOT_TBL = f_slot_tbl();

endpackage

`default_nettype wire

/* src/acs_if.sv */
`default_nettype none

// Command channel: step, program byte write, full reset
interface acs_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] prog_address;
    logic [7:0] prog_data;

    modport source (output valid, output func, output prog_address, output prog_data,
                    input ready);
    modport sink   (input valid, input func, input prog_address, input prog_data,
                    output ready);
endinterface

// Response channel: processor state after each transaction
interface acs_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] pc_value;
    logic [7:0] acc_value;
    logic       carry_flag;
    logic       overflow_flag;
    logic       nonzero_flag;
    logic       halted;
    logic [3:0] executed_opcode;

    modport source (output valid, output pc_value, output acc_value, output carry_flag,
                    output overflow_flag, output nonzero_flag, output halted,
                    output executed_opcode, input ready);
    modport sink   (input valid, input pc_value, input acc_value, input carry_flag,
                    input overflow_flag, input nonzero_flag, input halted,
                    input executed_opcode, output ready);
endinterface

`default_nettype wire

/* src/acs_ram.sv */
`default_nettype none

module acs_ram #(
    parameter int               DEPTH     = 256,
    parameter int               WIDTH     = 8,
    parameter logic [WIDTH-1:0] RESET_VAL = '0,
    localparam int              AW        = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rdata;
    logic             r_rvalid;

    // Track written entries; unwritten ones read as the reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata  <= r_mem[i_raddr];
        r_rvalid <= r_valid[i_raddr];
    end

    assign o_rdata = r_rvalid ? r_rdata : RESET_VAL;

endmodule

`default_nettype wire

/* src/acs_alu.sv */
`default_nettype none

module acs_alu import acs_pkg::*; (
    input  t_alu_in  i_x,
    input  t_alu_in  i_y,
    input  logic     i_sub,
    output t_alu_out o_sum
);

    // Add or subtract; top bit is carry on add, borrow on subtract
    always_comb begin
        if (i_sub) begin
            o_sum = {1'b0, i_x} - {1'b0, i_y};
        end else begin
            o_sum = {1'b0, i_x} + {1'b0, i_y};
        end
    end

endmodule

`default_nettype wire

/* src/acs_ctrl.sv */
`default_nettype none

module acs_ctrl import acs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    acs_cmd_if.sink   i_cmd,
    acs_rsp_if.source o_rsp,
    output t_ram_req o_prog_req,
    input  t_byte    i_prog_rdata,
    output t_ram_req o_data_req,
    input  t_byte    i_data_rdata
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_OPC  = 7'b0000010,
        S_OPD  = 7'b0000100,
        S_MEM  = 7'b0001000,
        S_EXEC = 7'b0010000,
        S_ITER = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    localparam logic [CNT_W-1:0] ITER_LAST = CNT_W'(ITER_STEPS - 1);

    t_state r_state, n_state;
    // Architectural state
    t_byte  r_acc, n_acc;
    t_byte  r_pc, n_pc;
    logic   r_carry, n_carry;
    logic   r_ovf, n_ovf;
    logic   r_nz, n_nz;
    logic   r_halt, n_halt;
    // Working registers for one step
    t_opcode r_opc, n_opc;
    t_byte   r_opd, n_opd;
    t_byte   r_m, n_m;
    t_byte   r_hi, n_hi;
    t_byte   r_lo, n_lo;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    // Output register
    logic    r_out_valid, n_out_valid;
    t_byte   r_out_pc, n_out_pc;
    t_byte   r_out_acc, n_out_acc;
    logic    r_out_carry, n_out_carry;
    logic    r_out_ovf, n_out_ovf;
    logic    r_out_nz, n_out_nz;
    logic    r_out_halt, n_out_halt;
    t_opcode r_out_opc, n_out_opc;

    logic     accept;
    t_byte    pc_inc;
    t_alu_in  alu_x, alu_y;
    logic     alu_sub;
    t_alu_out alu_sum;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign pc_inc      = r_pc + 8'd1;

    // Select operands of the shared adder
    always_comb begin
        alu_x   = {1'b0, r_acc};
        alu_y   = {1'b0, r_m};
        alu_sub = 1'b0;
        if (r_state == S_ITER) begin
            if (r_opc == OP_MUL) begin
                alu_x = {1'b0, r_hi};
                alu_y = r_lo[0] ? {1'b0, r_m} : '0;
            end else begin
                alu_x   = {r_hi, r_lo[7]};
                alu_sub = 1'b1;
            end
        end else begin
            unique case (r_opc)
                OP_SUB: alu_sub = 1'b1;
                OP_INC: alu_y = ALU_W'(1);
                OP_DEC: begin
                    alu_y   = ALU_W'(1);
                    alu_sub = 1'b1;
                end
                default: ;
            endcase
        end
    end

    acs_alu u_alu (
        .i_x   (alu_x),
        .i_y   (alu_y),
        .i_sub (alu_sub),
        .o_sum (alu_sum)
    );

    // Sequencer and datapath
    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_pc        = r_pc;
        n_carry     = r_carry;
        n_ovf       = r_ovf;
        n_nz        = r_nz;
        n_halt      = r_halt;
        n_opc       = r_opc;
        n_opd       = r_opd;
        n_m         = r_m;
        n_hi        = r_hi;
        n_lo        = r_lo;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_pc    = r_out_pc;
        n_out_acc   = r_out_acc;
        n_out_carry = r_out_carry;
        n_out_ovf   = r_out_ovf;
        n_out_nz    = r_out_nz;
        n_out_halt  = r_out_halt;
        n_out_opc   = r_out_opc;

        o_prog_req       = '0;
        o_prog_req.raddr = SLOT_TBL[r_pc];
        o_data_req       = '0;
        o_data_req.raddr = SLOT_TBL[i_prog_rdata];

        // Drop the output transaction once taken
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_opc   = OP_LDM;
                    n_state = S_DONE;
                    unique case (t_func'(i_cmd.func))
                        FUNC_STEP: n_state = S_OPC;
                        FUNC_WRITE: begin
                            o_prog_req.we    = 1'b1;
                            o_prog_req.waddr = SLOT_TBL[i_cmd.prog_address];
                            o_prog_req.wdata = i_cmd.prog_data;
                        end
                        FUNC_RESET: begin
                            o_prog_req.clear = 1'b1;
                            o_data_req.clear = 1'b1;
                            n_acc   = '0;
                            n_pc    = '0;
                            n_carry = 1'b0;
                            n_ovf   = 1'b0;
                            n_nz    = 1'b0;
                            n_halt  = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_OPC: begin
                // Opcode byte arrived; fetch operand
                n_opc            = t_opcode'(i_prog_rdata[3:0]);
                o_prog_req.raddr = SLOT_TBL[pc_inc];
                n_pc             = pc_inc;
                n_state          = S_OPD;
            end
            S_OPD: begin
                // Operand arrived; read data store at operand
                n_opd   = i_prog_rdata;
                n_pc    = pc_inc;
                n_state = S_MEM;
            end
            S_MEM: begin
                n_m     = i_data_rdata;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_DONE;
                if (r_opc != OP_HALT) begin
                    n_carry = 1'b0;
                    n_ovf   = 1'b0;
                end
                unique case (r_opc) inside
                    OP_LDM: n_acc = r_m;
                    OP_LDI: n_acc = r_opd;
                    OP_STM: begin
                        o_data_req.we    = 1'b1;
                        o_data_req.waddr = SLOT_TBL[r_opd];
                        o_data_req.wdata = r_acc;
                    end
                    OP_ADD, OP_INC: begin
                        n_acc   = alu_sum[7:0];
                        n_carry = alu_sum[8];
                    end
                    OP_SUB, OP_DEC: begin
                        n_acc = alu_sum[7:0];
                        n_ovf = alu_sum[ALU_W];
                    end
                    OP_MUL, OP_DIV: begin
                        if (r_opc == OP_DIV && r_m == '0) begin
                            n_acc = DIV_ZERO_Q;
                        end else begin
                            n_hi    = '0;
                            n_lo    = r_acc;
                            n_cnt   = '0;
                            n_state = S_ITER;
                        end
                    end
                    OP_AND: n_acc = r_acc & r_m;
                    OP_OR:  n_acc = r_acc | r_m;
                    OP_NOT: n_acc = ~r_m;
                    OP_JMP: n_pc = r_opd;
                    OP_JZ: begin
                        if (!r_nz) begin
                            n_pc = r_opd;
                        end
                    end
                    OP_JNZ: begin
                        if (r_nz) begin
                            n_pc = r_opd;
                        end
                    end
                    OP_HALT: begin
                        n_pc   = r_pc - 8'd2;
                        n_halt = 1'b1;
                    end
                    default: ;
                endcase
                n_nz = (n_acc != '0);
            end
            S_ITER: begin
                // One bit of multiply or divide per cycle
                if (r_opc == OP_MUL) begin
                    n_hi = alu_sum[8:1];
                    n_lo = {alu_sum[0], r_lo[7:1]};
                end else if (!alu_sum[ALU_W]) begin
                    n_hi = alu_sum[7:0];
                    n_lo = {r_lo[6:0], 1'b1};
                end else begin
                    n_hi = {r_hi[6:0], r_lo[7]};
                    n_lo = {r_lo[6:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == ITER_LAST) begin
                    n_acc = n_lo;
                    if (r_opc == OP_MUL) begin
                        n_ovf = (n_hi != '0);
                    end
                    n_nz    = (n_lo != '0);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_pc    = r_pc;
                    n_out_acc   = r_acc;
                    n_out_carry = r_carry;
                    n_out_ovf   = r_ovf;
                    n_out_nz    = r_nz;
                    n_out_halt  = r_halt;
                    n_out_opc   = r_opc;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control and architectural registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
            r_pc        <= '0;
            r_carry     <= 1'b0;
            r_ovf       <= 1'b0;
            r_nz        <= 1'b0;
            r_halt      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_acc       <= n_acc;
            r_pc        <= n_pc;
            r_carry     <= n_carry;
            r_ovf       <= n_ovf;
            r_nz        <= n_nz;
            r_halt      <= n_halt;
        end
    end

    // Working and output payload registers
    always_ff @(posedge i_clk) begin
        r_opc       <= n_opc;
        r_opd       <= n_opd;
        r_m         <= n_m;
        r_hi        <= n_hi;
        r_lo        <= n_lo;
        r_cnt       <= n_cnt;
        r_out_pc    <= n_out_pc;
        r_out_acc   <= n_out_acc;
        r_out_carry <= n_out_carry;
        r_out_ovf   <= n_out_ovf;
        r_out_nz    <= n_out_nz;
        r_out_halt  <= n_out_halt;
        r_out_opc   <= n_out_opc;
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.pc_value        = r_out_pc;
    assign o_rsp.acc_value       = r_out_acc;
    assign o_rsp.carry_flag      = r_out_carry;
    assign o_rsp.overflow_flag   = r_out_ovf;
    assign o_rsp.nonzero_flag    = r_out_nz;
    assign o_rsp.halted          = r_out_halt;
    assign o_rsp.executed_opcode = r_out_opc;

endmodule

`default_nettype wire

/* src/accumulator_cpu_step_top.sv */
`default_nettype none

// 8-bit accumulator processor with a 256-byte program store and a 256-byte data
// store. Each command transaction returns one response transaction carrying
// pc, accumulator, flags, halt mark and the executed opcode. An execute step
// runs a small sequencer on stores with registered reads: opcode fetch,
// operand fetch, data read, execute and response. Multiply and divide by a
// nonzero divisor run one bit per cycle through a shared 9-bit add/subtract
// unit, while a divide by zero returns 0xFF without iterating. A program byte
// write, a full reset or an unused command goes straight from acceptance to
// the response. The command side is busy during a step but accepts a new
// command while a response still waits. Both stores come up in their reset
// contents at once.

module accumulator_cpu_step_top import acs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    acs_cmd_if.sink   i_cmd,
    acs_rsp_if.source o_rsp
);

    t_ram_req prog_req;
    t_ram_req data_req;
    t_byte    prog_rdata;
    t_byte    data_rdata;

    acs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .o_rsp        (o_rsp),
        .o_prog_req   (prog_req),
        .i_prog_rdata (prog_rdata),
        .o_data_req   (data_req),
        .i_data_rdata (data_rdata)
    );

    // Program store, halt opcode until written
    acs_ram #(
        .DEPTH     (STORE_DEPTH),
        .WIDTH     (8),
        .RESET_VAL (HALT_FILL)
    ) u_prog_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (prog_req.clear),
        .i_we    (prog_req.we),
        .i_waddr (prog_req.waddr),
        .i_wdata (prog_req.wdata),
        .i_raddr (prog_req.raddr),
        .o_rdata (prog_rdata)
    );

    // Data store, zero until written
    acs_ram #(
        .DEPTH     (STORE_DEPTH),
        .WIDTH     (8),
        .RESET_VAL (8'h00)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (data_req.clear),
        .i_we    (data_req.we),
        .i_waddr (data_req.waddr),
        .i_wdata (data_req.wdata),
        .i_raddr (data_req.raddr),
        .o_rdata (data_rdata)
    );

endmodule

`default_nettype wire
